### hw/rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants, types and helpers of the sliding window median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

	// default sizing
	localparam int WINDOW_MAX_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 32;

	// configuration register
	localparam int CFG_BITS  = 7;
	localparam int WIN_RESET = 3;

	// fixed port width of the sample and the median
	localparam int PORT_BITS = 32;

	// broadcast from the sequencer to every cell of the row
	typedef struct packed {
		logic step;   // cells take their next value
		logic full;   // window full, the oldest key leaves this step
	} cell_cmd_t;

	// window length the register stands for, clamped to 1..wmax
	function automatic int eff_window(input logic [CFG_BITS-1:0] raw, input int wmax);
		int w;
		w = int'(raw);
		if (w < 1) w = 1;
		if (w > wmax) w = wmax;
		return w;
	endfunction

endpackage

### hw/rtl/sliding_window_median.sv
// ----------------------------------------------------------------------------
// sliding_window_median
// Running median over the last window_size samples: a row of compare cells
// keeps the window sorted, an arrival ring supplies the key that leaves.
// ----------------------------------------------------------------------------
// Each sample goes through cell row step, middle slot pick and median sum in
//   turn; a new sample is taken only after its sum, which waits while an
//   unread result is held. A result appears only once the window is full.
// Reset: window_size is 3 and the window is empty; cell and ring contents
//   are undefined and never read before being written, so no clearing pass.
// ----------------------------------------------------------------------------
module sliding_window_median #(
	parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [swm_pkg::CFG_BITS-1:0]        window_size,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [swm_pkg::PORT_BITS-1:0] sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [swm_pkg::PORT_BITS-1:0] median_floor,
	output logic                                median_half
);
	import swm_pkg::*;

	localparam int CNT_W = $clog2(WINDOW_MAX + 1);
	localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam logic [CNT_W-1:0] WIN_RST = CNT_W'(eff_window(CFG_BITS'(WIN_RESET), WINDOW_MAX));

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_PICK,
		ST_SUM
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       win_q;
	logic [CNT_W-1:0]       fill_q;
	logic [IDX_W-1:0]       pos_q;
	logic                   emit_q;
	logic                   out_valid_q;

	logic [SAMPLE_BITS-1:0] ring_q [WINDOW_MAX];
	logic [SAMPLE_BITS-1:0] ring_rd_q;
	logic [SAMPLE_BITS-1:0] key_q;
	logic [SAMPLE_BITS-1:0] mid_lo_q;
	logic [SAMPLE_BITS-1:0] mid_hi_q;
	logic signed [PORT_BITS-1:0] median_floor_q;
	logic                   median_half_q;

	logic                   cfg_acc;
	logic                   in_acc;
	logic                   full;
	logic                   sum_load;
	logic [CNT_W-1:0]       fill_inc;
	logic [CNT_W-1:0]       pos_inc;
	logic [CNT_W-1:0]       mid_hi_c;
	logic [CNT_W-1:0]       mid_lo_c;
	logic [SAMPLE_BITS-1:0] key_in;
	logic [SAMPLE_BITS:0]   mid_sum;
	logic signed [SAMPLE_BITS-1:0] med_val;
	logic [SAMPLE_BITS-1:0] vals [WINDOW_MAX];
	cell_cmd_t              cmd;

	// handshakes, configuration wins a tie
	assign cfg_ready = (state_q == ST_IDLE);
	assign in_ready  = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign in_acc    = in_valid && in_ready;

	// offset-binary key so that an unsigned compare orders the samples
	assign key_in = {~sample[SAMPLE_BITS-1], sample[SAMPLE_BITS-2:0]};

	// window bookkeeping
	assign full     = (fill_q == win_q);
	assign fill_inc = fill_q + CNT_W'(1);
	assign pos_inc  = CNT_W'(pos_q) + CNT_W'(1);
	assign sum_load = (state_q == ST_SUM) && (!emit_q || !out_valid_q || out_ready);

	// middle slots: the same one for an odd window
	assign mid_hi_c = win_q >> 1;
	assign mid_lo_c = win_q[0] ? mid_hi_c : (mid_hi_c - CNT_W'(1));

	// sorted window
	assign cmd.step = (state_q == ST_UPD);
	assign cmd.full = full;

	swm_cell_row #(
		.WINDOW_MAX (WINDOW_MAX),
		.SAMPLE_BITS(SAMPLE_BITS),
		.CNT_W      (CNT_W)
	) u_row (
		.clk   (clk),
		.cmd   (cmd),
		.fill  (fill_q),
		.key   (key_q),
		.oldest(ring_rd_q),
		.vals  (vals)
	);

	// median from the two middle keys, exact in one extra bit
	assign mid_sum = {1'b0, mid_lo_q} + {1'b0, mid_hi_q};
	assign med_val = {~mid_sum[SAMPLE_BITS], mid_sum[SAMPLE_BITS-1:1]};

	// sequencer, window counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			win_q       <= WIN_RST;
			fill_q      <= '0;
			pos_q       <= '0;
			emit_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// result set at the end of a median sum, cleared by its transaction
			if (sum_load && emit_q) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_acc) begin
						win_q  <= CNT_W'(eff_window(window_size, WINDOW_MAX));
						fill_q <= '0;
						pos_q  <= '0;
					end else if (in_acc) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (!full) begin
						fill_q <= fill_inc;
					end
					emit_q  <= full || (fill_inc == win_q);
					pos_q   <= (pos_inc == win_q) ? '0 : pos_inc[IDX_W-1:0];
					state_q <= ST_PICK;
				end
				ST_PICK: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (sum_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers and arrival ring
	always_ff @(posedge clk) begin
		if (in_acc) begin
			key_q     <= key_in;
			ring_rd_q <= ring_q[pos_q];
		end
		if (state_q == ST_UPD) begin
			ring_q[pos_q] <= key_q;
		end
		if (state_q == ST_PICK) begin
			mid_lo_q <= vals[mid_lo_c[IDX_W-1:0]];
			mid_hi_q <= vals[mid_hi_c[IDX_W-1:0]];
		end
		if (sum_load && emit_q) begin
			median_floor_q <= PORT_BITS'(med_val);
			median_half_q  <= mid_sum[0];
		end
	end

	assign out_valid    = out_valid_q;
	assign median_floor = median_floor_q;
	assign median_half  = median_half_q;

	// a result only appears at the end of the median sum
	a_out_from_sum: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_SUM))
		else $error("result valid without a median sum");

	// the window never holds more keys than its length
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= win_q)
		else $error("fill count beyond window length");

	// the ring slot stays inside the window
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(pos_q) < win_q)
		else $error("ring slot beyond window length");

	// an accepted sample always steps the cell row next
	a_step_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_UPD))
		else $error("sample transaction did not step the cell row");

endmodule

### hw/rtl/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the sorted window. Holds one offset-binary key and, in one
// step, removes the oldest key and inserts the new one using only the
// compare flags and values of its two neighbors beside the broadcast keys.
// ----------------------------------------------------------------------------
module swm_cell #(
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  swm_pkg::cell_cmd_t     cmd,
	input  logic                   occupied,
	input  logic [SAMPLE_BITS-1:0] key,
	input  logic [SAMPLE_BITS-1:0] oldest,
	input  logic                   left_rg,
	input  logic [SAMPLE_BITS-1:0] left_r,
	input  logic                   right_g,
	input  logic [SAMPLE_BITS-1:0] right_v,
	output logic                   own_g,
	output logic [SAMPLE_BITS-1:0] own_v,
	output logic                   out_rg,
	output logic [SAMPLE_BITS-1:0] out_r
);
	import swm_pkg::*;

	logic [SAMPLE_BITS-1:0] v_q;
	logic                   del_at;
	logic [SAMPLE_BITS-1:0] nxt;

	// empty slots act as +infinity for both compares
	assign own_g  = !occupied || (v_q > key);
	assign del_at = cmd.full && (!occupied || (v_q >= oldest));

	// view of this slot after the oldest key is taken out
	assign out_rg = del_at ? right_g : own_g;
	assign out_r  = del_at ? right_v : v_q;
	assign own_v  = v_q;

	// shift right past the insertion point, key at it, keep before it
	always_comb begin
		if (left_rg) begin
			nxt = left_r;
		end else if (out_rg) begin
			nxt = key;
		end else begin
			nxt = out_r;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			v_q <= nxt;
		end
	end

endmodule

### hw/rtl/swm_cell_row.sv
// ----------------------------------------------------------------------------
// swm_cell_row
// Row of WINDOW_MAX cells holding the window in ascending key order.
// Slots below the fill count are occupied.
// ----------------------------------------------------------------------------
module swm_cell_row #(
	parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
	parameter int CNT_W       = $clog2(WINDOW_MAX + 1)
) (
	input  logic                   clk,
	input  swm_pkg::cell_cmd_t     cmd,
	input  logic [CNT_W-1:0]       fill,
	input  logic [SAMPLE_BITS-1:0] key,
	input  logic [SAMPLE_BITS-1:0] oldest,
	output logic [SAMPLE_BITS-1:0] vals [WINDOW_MAX]
);
	import swm_pkg::*;

	// neighbor links, index i is the link between cell i-1 and cell i
	logic                   rg_w [WINDOW_MAX+1];
	logic [SAMPLE_BITS-1:0] r_w  [WINDOW_MAX+1];
	logic                   g_w  [WINDOW_MAX+1];
	logic [SAMPLE_BITS-1:0] v_w  [WINDOW_MAX+1];

	// row ends: nothing shifts in from the left, +infinity on the right
	assign rg_w[0]         = 1'b0;
	assign r_w[0]          = '0;
	assign g_w[WINDOW_MAX] = 1'b1;
	assign v_w[WINDOW_MAX] = '0;

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		logic occ;

		assign occ = (CNT_W'(i) < fill);

		swm_cell #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.occupied(occ),
			.key     (key),
			.oldest  (oldest),
			.left_rg (rg_w[i]),
			.left_r  (r_w[i]),
			.right_g (g_w[i+1]),
			.right_v (v_w[i+1]),
			.own_g   (g_w[i]),
			.own_v   (v_w[i]),
			.out_rg  (rg_w[i+1]),
			.out_r   (r_w[i+1])
		);

		assign vals[i] = v_w[i];
	end

endmodule
